// ----- rtl/core/csb_pkg.sv -----
// csb_pkg: shared codes, widths and control structs of the circular string buffer
// no dependencies; imported by the channel interfaces, csb_ctrl, csb_dp and circular_string_buffer

package csb_pkg;

   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;

   // request command codes
   localparam logic CMD_PUT = 1'b0;
   localparam logic CMD_GET = 1'b1;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_ACCEPTED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BYTE     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd3;

   localparam logic [BYTE_W-1:0] TERMINATOR = 8'h00;

   // controller to datapath
   typedef struct packed {
      logic put;        // put byte transferred this cycle
      logic get_start;  // get transferred this cycle
      logic pop;        // emit the byte at the read pointer
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic term;   // request byte is the terminator
      logic empty;  // nothing committed
      logic last;   // byte being popped ends the string
   } dp_sts_type;

endpackage

// ----- rtl/core/csb_if.sv -----
// csb_req_bus / csb_rsp_bus: valid-ready channels of the circular string buffer
// depends on csb_pkg for field widths

interface csb_req_bus import csb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output cmd, output data_byte, input ready);
   modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface csb_rsp_bus import csb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [BYTE_W-1:0]   out_byte;
   logic                out_last;

   modport source (output valid, output status, output out_byte, output out_last,
                   input ready);
   modport sink   (input valid, input status, input out_byte, input out_last,
                   output ready);
endinterface

// ----- rtl/core/csb_ram.sv -----
// csb_ram: generic single-write, single-read RAM with registered read data
// no dependencies

module csb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/csb_ctrl.sv -----
// csb_ctrl: handshake and sequencing controller of the circular string buffer
// depends on csb_pkg; drives csb_dp through dp_cmd_type / dp_sts_type

module csb_ctrl import csb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_cmd,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type dp_cmd,
   input  dp_sts_type dp_sts
);

   localparam logic [0:0] ST_IDLE = 1'b0;
   localparam logic [0:0] ST_GET  = 1'b1;

   logic [0:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       accept;
   logic       load;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   assign dp_cmd.put       = accept && (req_cmd == CMD_PUT);
   assign dp_cmd.get_start = accept && (req_cmd == CMD_GET);
   assign dp_cmd.pop       = (state_ff == ST_GET) && out_free;

   assign load = (dp_cmd.put && dp_sts.term) || (dp_cmd.get_start && dp_sts.empty) ||
                 dp_cmd.pop;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (dp_cmd.get_start && !dp_sts.empty) begin
               state_in = ST_GET;
            end
         end
         ST_GET: begin
            if (dp_cmd.pop && dp_sts.last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      priority if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // no request is taken while a string is being popped
   a_no_accept_in_get: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GET) |-> !req_ready)
      else $error("request taken during a get");

   // every popped byte shows up on the response register
   a_pop_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.pop |=> rsp_valid_ff)
      else $error("popped byte not presented");

endmodule

// ----- rtl/core/csb_dp.sv -----
// csb_dp: pointers, overflow flag, byte store and response register
// depends on csb_pkg and csb_ram; sequenced by csb_ctrl

module csb_dp import csb_pkg::*; #(
   parameter int DEPTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          dp_cmd,
   output dp_sts_type          dp_sts,
   input  logic [BYTE_W-1:0]   req_data_byte,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [BYTE_W-1:0]   rsp_out_byte,
   output logic                rsp_out_last
);

   localparam int IW = $clog2(DEPTH);

   // pointer counts modulo 2*DEPTH as a wrap bit over an index 0..DEPTH-1
   typedef struct packed {
      logic          wrap;
      logic [IW-1:0] idx;
   } ptr_type;

   function automatic ptr_type ptr_next(ptr_type p);
      ptr_type n;
      if (p.idx == IW'(DEPTH - 1)) begin
         n.idx  = '0;
         n.wrap = !p.wrap;
      end else begin
         n.idx  = p.idx + 1'b1;
         n.wrap = p.wrap;
      end
      return n;
   endfunction

   function automatic logic [IW:0] ptr_level(ptr_type ahead, ptr_type behind);
      logic [IW:0] ext;
      ext = (ahead.wrap != behind.wrap) ? (IW + 1)'(DEPTH) : '0;
      return {1'b0, ahead.idx} + ext - {1'b0, behind.idx};
   endfunction

   ptr_type rd_ff, rd_in;
   ptr_type cm_ff, cm_in;
   ptr_type wr_ff, wr_in;
   logic    drop_ff, drop_in;

   logic [STATUS_W-1:0] status_ff, status_in;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic                last_ff, last_in;

   ptr_type           rd_nxt, wr_nxt;
   logic [IW:0]       wr_level, cm_level;
   logic              full;
   logic              store;
   logic              ram_rd_en;
   logic [IW-1:0]     ram_rd_addr;
   logic [BYTE_W-1:0] ram_rd_data;

   assign rd_nxt   = ptr_next(rd_ff);
   assign wr_nxt   = ptr_next(wr_ff);
   assign wr_level = ptr_level(wr_ff, rd_ff);
   assign cm_level = ptr_level(cm_ff, rd_ff);
   assign full     = (wr_level >= (IW + 1)'(DEPTH));
   assign store    = dp_cmd.put && !drop_ff && !full;

   assign dp_sts.term  = (req_data_byte == TERMINATOR);
   assign dp_sts.empty = (cm_ff == rd_ff);
   assign dp_sts.last  = (ram_rd_data == TERMINATOR) || (rd_nxt == cm_ff);

   // prefetch the next byte while the current one is emitted
   assign ram_rd_en   = dp_cmd.get_start || dp_cmd.pop;
   assign ram_rd_addr = dp_cmd.pop ? rd_nxt.idx : rd_ff.idx;

   csb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (wr_ff.idx),
      .wr_data (req_data_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      rd_in   = rd_ff;
      cm_in   = cm_ff;
      wr_in   = wr_ff;
      drop_in = drop_ff;
      if (dp_cmd.put) begin
         priority if (store) begin
            wr_in = wr_nxt;
            if (dp_sts.term) begin
               cm_in = wr_nxt;
            end
         end else if (dp_sts.term) begin
            wr_in   = cm_ff;
            drop_in = 1'b0;
         end else begin
            drop_in = 1'b1;
         end
      end
      if (dp_cmd.pop) begin
         rd_in = rd_nxt;
      end
   end

   always_comb begin
      status_in = status_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      priority if (dp_cmd.put && dp_sts.term) begin
         status_in = store ? STATUS_ACCEPTED : STATUS_REJECTED;
         byte_in   = '0;
         last_in   = 1'b1;
      end else if (dp_cmd.get_start && dp_sts.empty) begin
         status_in = STATUS_EMPTY;
         byte_in   = '0;
         last_in   = 1'b1;
      end else if (dp_cmd.pop) begin
         status_in = STATUS_BYTE;
         byte_in   = ram_rd_data;
         last_in   = dp_sts.last;
      end else begin
         status_in = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff   <= '0;
         cm_ff   <= '0;
         wr_ff   <= '0;
         drop_ff <= 1'b0;
      end else begin
         rd_ff   <= rd_in;
         cm_ff   <= cm_in;
         wr_ff   <= wr_in;
         drop_ff <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      byte_ff   <= byte_in;
      last_ff   <= last_in;
   end

   assign rsp_status   = status_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_out_last = last_ff;

   // the speculative fill never exceeds the ring
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      wr_level <= (IW + 1)'(DEPTH))
      else $error("write pointer ran past the ring");

   // committed bytes are a prefix of the written ones
   a_commit_behind_write: assert property (@(posedge clock) disable iff (reset)
      cm_level <= wr_level)
      else $error("commit pointer ahead of write pointer");

   // a string that ends without its terminator ends at the commit point
   a_pop_stops_at_commit: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.pop && dp_sts.last && (ram_rd_data != TERMINATOR)) |=> (rd_ff == cm_ff))
      else $error("get stopped short of the commit pointer");

endmodule

// ----- rtl/core/circular_string_buffer.sv -----
// circular_string_buffer: top level of the ring buffer of zero-terminated strings
// depends on csb_pkg, csb_if (channel interfaces), csb_ctrl, csb_dp and csb_ram

// A request with cmd put hands over one string byte; bytes land in a ring of DEPTH bytes
// at a speculative write pointer, and the zero terminator commits the string and answers
// accepted. If the ring fills first, the rest of the string is dropped and the terminator
// answers rejected (full); a non-terminator put gives no response. A request with cmd get
// pops the oldest committed string one byte per response, terminator included, with
// out_last on its final byte, or answers empty with out_last set. Puts and empty gets
// stream back to back while the response channel does not stall; a get holds the
// request channel until its last byte is popped, since the byte store has one
// registered read port: the first byte is read at the get transfer, after which the next
// byte is prefetched while the current one is presented. The response register lets a new
// request transfer in the cycle its predecessor's last response transfers. The byte store
// has no reset and needs no clearing pass: only committed bytes are ever presented.

module circular_string_buffer import csb_pkg::*; #(
   parameter int DEPTH = 32
) (
   input logic          clock,
   input logic          reset,
   csb_req_bus.sink     req_bus,
   csb_rsp_bus.source   rsp_bus
);

   // command and status between the sequencer and the datapath
   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   // sequencer: owns both handshakes and the idle / get state
   csb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_cmd   (req_bus.cmd),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .dp_cmd    (dp_cmd),
      .dp_sts    (dp_sts)
   );

   // datapath: ring pointers, overflow flag, byte store and response payload
   csb_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .dp_cmd        (dp_cmd),
      .dp_sts        (dp_sts),
      .req_data_byte (req_bus.data_byte),
      .rsp_status    (rsp_bus.status),
      .rsp_out_byte  (rsp_bus.out_byte),
      .rsp_out_last  (rsp_bus.out_last)
   );

endmodule
